// File: src/kic_pkg.sv
// ----------------------------------------------------------------------------
// kic_pkg: shared types and constants of the keypad integer calculator
// Key codes, pending operation codes, sequencer states and the command and
// status bundles between the sequencer and the multiply/divide unit.
// ----------------------------------------------------------------------------
package kic_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int MODE_WIDTH          = 3;
   localparam int DIGIT_WIDTH         = 4;
   localparam int DISPLAY_WIDTH       = 32;
   localparam int DECIMAL_BASE        = 10;

   typedef enum logic [MODE_WIDTH-1:0] {
      KEY_DIGIT  = 3'd0,
      KEY_EQUALS = 3'd1,
      KEY_CLEAR  = 3'd2,
      KEY_BACK   = 3'd3,
      KEY_ADD    = 3'd4,
      KEY_SUB    = 3'd5,
      KEY_MUL    = 3'd6,
      KEY_DIV    = 3'd7
   } kic_key_type;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } kic_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAIT,
      ST_WRITE
   } kic_state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } kic_unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } kic_unit_sts_type;

endpackage

// File: src/kic_if.sv
// ----------------------------------------------------------------------------
// kic_if: key and display channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface kic_req_if;
   logic                         valid;
   logic                         ready;
   logic [kic_pkg::MODE_WIDTH-1:0]  mode;
   logic [kic_pkg::DIGIT_WIDTH-1:0] digit;

   modport source (output valid, output mode, output digit, input ready);
   modport sink   (input valid, input mode, input digit, output ready);
endinterface

interface kic_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [kic_pkg::DISPLAY_WIDTH-1:0] display_value;

   modport source (output valid, output display_value, input ready);
   modport sink   (input valid, input display_value, output ready);
endinterface

// File: src/kic_muldiv.sv
// ----------------------------------------------------------------------------
// kic_muldiv: iterative multiply / signed divide unit
// One shared adder per cycle: shift-add multiply or restoring divide,
// one bit a step, VALUE_WIDTH steps per operation.
// ----------------------------------------------------------------------------
module kic_muldiv
   import kic_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kic_unit_cmd_type       cmd,
   input  logic [VALUE_WIDTH-1:0] opa,
   input  logic [VALUE_WIDTH-1:0] opb,
   output kic_unit_sts_type       sts,
   output logic [VALUE_WIDTH-1:0] result
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic                   running_ff, running_in;
   logic                   done_ff, done_in;
   logic                   is_div_ff, is_div_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;

   logic [VALUE_WIDTH:0]   add_x;
   logic [VALUE_WIDTH:0]   add_y;
   logic [VALUE_WIDTH+1:0] add_sum;
   logic                   fits;
   logic [VALUE_WIDTH-1:0] mag_a;
   logic [VALUE_WIDTH-1:0] mag_b;

   // shared adder: accumulate for multiply, trial subtract for divide
   always_comb begin
      if (is_div_ff) begin
         add_x = {acc_ff, a_ff[VALUE_WIDTH-1]};
         add_y = {1'b0, b_ff};
      end else begin
         add_x = {1'b0, acc_ff};
         add_y = {1'b0, (b_ff[0] ? a_ff : '0)};
      end
      add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(VALUE_WIDTH+1){is_div_ff}}}
                + (VALUE_WIDTH+2)'(is_div_ff);
      fits    = add_sum[VALUE_WIDTH+1];
   end

   assign mag_a = opa[VALUE_WIDTH-1] ? (~opa + 1'b1) : opa;
   assign mag_b = opb[VALUE_WIDTH-1] ? (~opb + 1'b1) : opb;

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      is_div_in  = is_div_ff;
      neg_in     = neg_ff;
      zero_in    = zero_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      if (cmd.start) begin
         running_in = 1'b1;
         is_div_in  = cmd.is_div;
         neg_in     = opa[VALUE_WIDTH-1] ^ opb[VALUE_WIDTH-1];
         zero_in    = (opb == '0);
         cnt_in     = CNT_W'(VALUE_WIDTH - 1);
         acc_in     = '0;
         a_in       = cmd.is_div ? mag_a : opa;
         b_in       = cmd.is_div ? mag_b : opb;
      end else if (running_ff) begin
         if (is_div_ff) begin
            acc_in = fits ? add_sum[VALUE_WIDTH-1:0] : add_x[VALUE_WIDTH-1:0];
            a_in   = {a_ff[VALUE_WIDTH-2:0], fits};
         end else begin
            acc_in = add_sum[VALUE_WIDTH-1:0];
            a_in   = {a_ff[VALUE_WIDTH-2:0], 1'b0};
            b_in   = b_ff >> 1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
   end

   // quotient sign fix; divide by zero gives zero
   always_comb begin
      if (!is_div_ff) begin
         result = acc_ff;
      end else if (zero_ff) begin
         result = '0;
      end else if (neg_ff) begin
         result = ~a_ff + 1'b1;
      end else begin
         result = a_ff;
      end
   end

   assign sts.busy = running_ff;
   assign sts.done = done_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !running_ff)
      else $error("unit started while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (done_ff && is_div_ff && zero_ff) |-> (result == '0))
      else $error("divide by zero did not give zero");
`endif

endmodule

// File: src/keypad_integer_calculator.sv
// ----------------------------------------------------------------------------
// keypad_integer_calculator: four-function integer keypad calculator
// Takes one key per transfer and returns the display value after that key.
// ----------------------------------------------------------------------------
// Flow: digit, clear, operator, and add/sub equals go from the key transfer
//   through the execute and write states to the display register; back and
//   mul/div equals also wait in ST_WAIT on the bit-serial multiply/divide unit.
//   No new key is taken until the display of the last key has been written to
//   the output register; a display left waiting holds the next write step.
// Reset: synchronous, active high; display, operand, pending operation and
//   new-number flag clear to zero, no display transfer pending.
// ----------------------------------------------------------------------------
module keypad_integer_calculator
   import kic_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   kic_req_if.sink      req_chan,
   kic_rsp_if.source    rsp_chan
);

   kic_state_type              state_ff, state_in;
   kic_key_type                key_ff, key_in;
   logic [DIGIT_WIDTH-1:0]     digit_ff, digit_in;
   logic [VALUE_WIDTH-1:0]     shown_ff, shown_in;
   logic [VALUE_WIDTH-1:0]     first_ff, first_in;
   kic_op_type                 pending_ff, pending_in;
   logic                       start_new_ff, start_new_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DISPLAY_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                       req_fire;
   logic                       out_free;
   logic                       needs_unit;
   logic [VALUE_WIDTH-1:0]     digit_ext;
   logic [VALUE_WIDTH-1:0]     ten;
   logic signed [DISPLAY_WIDTH-1:0] disp_next;

   kic_unit_cmd_type           unit_cmd;
   kic_unit_sts_type           unit_sts;
   logic [VALUE_WIDTH-1:0]     unit_a;
   logic [VALUE_WIDTH-1:0]     unit_b;
   logic [VALUE_WIDTH-1:0]     unit_result;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   // output slot is free once the held display has been transferred
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign digit_ext      = {{(VALUE_WIDTH-DIGIT_WIDTH){1'b0}}, digit_ff};
   assign ten            = VALUE_WIDTH'(DECIMAL_BASE);

   // back and multiply/divide equals go through the shared unit
   assign needs_unit = (key_ff == KEY_BACK) ||
                       ((key_ff == KEY_EQUALS) &&
                        ((pending_ff == OP_MUL) || (pending_ff == OP_DIV)));

   // back divides the display by ten; equals works on first operand and display
   assign unit_a = (key_ff == KEY_BACK) ? shown_ff : first_ff;
   assign unit_b = (key_ff == KEY_BACK) ? ten : shown_ff;

   // sign-extend or truncate the display to the output width
   generate
      if (VALUE_WIDTH >= DISPLAY_WIDTH) begin : g_trunc
         assign disp_next = shown_ff[DISPLAY_WIDTH-1:0];
      end else begin : g_sext
         assign disp_next = {{(DISPLAY_WIDTH-VALUE_WIDTH){shown_ff[VALUE_WIDTH-1]}},
                             shown_ff};
      end
   endgenerate

   kic_muldiv #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .opa    (unit_a),
      .opb    (unit_b),
      .sts    (unit_sts),
      .result (unit_result)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = needs_unit ? ST_WAIT : ST_WRITE;
         end
         ST_WAIT: begin
            if (unit_sts.done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and calculator state updates
   always_comb begin
      key_in       = key_ff;
      digit_in     = digit_ff;
      shown_in     = shown_ff;
      first_in     = first_ff;
      pending_in   = pending_ff;
      start_new_in = start_new_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      unit_cmd     = '0;
      case (state_ff)
         ST_IDLE: begin
            // hold the key until it has been executed
            if (req_fire) begin
               key_in   = kic_key_type'(req_chan.mode);
               digit_in = req_chan.digit;
            end
         end
         ST_EXEC: begin
            case (key_ff)
               KEY_DIGIT: begin
                  if (start_new_ff) begin
                     shown_in = digit_ext;
                  end else begin
                     // times ten as two shifts, wrapped to VALUE_WIDTH
                     shown_in = (shown_ff << 3) + (shown_ff << 1) + digit_ext;
                  end
                  start_new_in = 1'b0;
               end
               KEY_EQUALS: begin
                  case (pending_ff)
                     OP_ADD: shown_in = first_ff + shown_ff;
                     OP_SUB: shown_in = first_ff - shown_ff;
                     OP_MUL: begin
                        unit_cmd.start  = 1'b1;
                        unit_cmd.is_div = 1'b0;
                     end
                     OP_DIV: begin
                        unit_cmd.start  = 1'b1;
                        unit_cmd.is_div = 1'b1;
                     end
                     default: shown_in = shown_ff;
                  endcase
                  pending_in   = OP_NONE;
                  start_new_in = 1'b1;
               end
               KEY_CLEAR: begin
                  shown_in     = '0;
                  first_in     = '0;
                  pending_in   = OP_NONE;
                  start_new_in = 1'b0;
               end
               KEY_BACK: begin
                  unit_cmd.start  = 1'b1;
                  unit_cmd.is_div = 1'b1;
               end
               KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
                  // latch the display and arm a new number
                  first_in     = shown_ff;
                  start_new_in = 1'b1;
                  case (key_ff)
                     KEY_ADD: pending_in = OP_ADD;
                     KEY_SUB: pending_in = OP_SUB;
                     KEY_MUL: pending_in = OP_MUL;
                     default: pending_in = OP_DIV;
                  endcase
               end
               default: shown_in = shown_ff;
            endcase
         end
         ST_WAIT: begin
            if (unit_sts.done) shown_in = unit_result;
         end
         ST_WRITE: begin
            // advance the display into the output register when it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = disp_next;
            end
         end
         default: shown_in = shown_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shown_ff     <= '0;
         first_ff     <= '0;
         pending_ff   <= OP_NONE;
         start_new_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shown_ff     <= shown_in;
         first_ff     <= first_in;
         pending_ff   <= pending_in;
         start_new_ff <= start_new_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      digit_ff    <= digit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.display_value = rsp_data_ff;

`ifndef ASSERT_OFF
   a_wait_has_unit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> (unit_sts.busy || unit_sts.done))
      else $error("waiting on an idle unit");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |-> (state_ff == ST_WAIT))
      else $error("unit result arrived outside the wait state");

   a_equals_clears_op: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && ((key_ff == KEY_EQUALS) || (key_ff == KEY_CLEAR)))
      |=> (pending_ff == OP_NONE))
      else $error("pending operation survived equals or clear");

   a_operator_arms: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && ((key_ff == KEY_ADD) || (key_ff == KEY_SUB) ||
       (key_ff == KEY_MUL) || (key_ff == KEY_DIV))) |=> start_new_ff)
      else $error("operator key did not arm a new number");
`endif

endmodule
